// ----- hw/rtl/cdd_pkg.sv -----
// cdd_pkg: shared types and constants for the code distance diagram block
// request and result payloads, cell link type, command codes
// no dependencies
package cdd_pkg;

    localparam int MAX_BITS = 12;
    localparam int HALF_BITS = MAX_BITS / 2;
    localparam int LEN_W = 4;
    localparam int DIST_W = 4;
    localparam int IDX_W = 11;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]          func;
        logic [MAX_BITS-1:0] word;
    } cmd_t;

    typedef struct packed {
        logic [HALF_BITS-1:0] row;
        logic [HALF_BITS-1:0] column;
        logic [DIST_W-1:0]    distance;
        logic [IDX_W-1:0]     codeword_index;
    } res_t;

    // one codeword travelling down the compare chain
    typedef struct packed {
        logic                valid;
        logic [MAX_BITS-1:0] cw;
        logic [DIST_W-1:0]   dsum;
    } link_t;

endpackage

// ----- hw/rtl/cdd_cell.sv -----
// cdd_cell: one bit position of the compare chain
// holds one query bit, adds its mismatch to the running distance
// depends on cdd_pkg
module cdd_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic          q_bit,
    input  logic          en_bit,
    input  cdd_pkg::link_t link_in,
    output cdd_pkg::link_t link_out
);

    logic                         q_bit_reg;
    logic                         en_bit_reg;
    logic                         valid_reg;
    logic [cdd_pkg::MAX_BITS-1:0] cw_reg;
    logic [cdd_pkg::DIST_W-1:0]   dsum_reg;
    cdd_pkg::link_t               out_next;
    logic                         miss;

    always_comb
    begin
        miss = (link_in.cw[0] ^ q_bit_reg) & en_bit_reg;
        out_next.valid = link_in.valid;
        // shift so the next cell always looks at bit 0
        out_next.cw = link_in.cw >> 1;
        out_next.dsum = link_in.dsum + cdd_pkg::DIST_W'(miss);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= out_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cw_reg <= out_next.cw;
        dsum_reg <= out_next.dsum;
        if (load)
        begin
            q_bit_reg <= q_bit;
            en_bit_reg <= en_bit;
        end
    end

    assign link_out.valid = valid_reg;
    assign link_out.cw = cw_reg;
    assign link_out.dsum = dsum_reg;

endmodule

// ----- hw/rtl/code_distance_diagram.sv -----
// code_distance_diagram: top level, codeword store, sweep sequencer, result register
// uses cdd_pkg and a chain of cdd_cell, one cell per bit position
// depends on cdd_pkg, cdd_cell
//
// Clear and load requests are handled in the idle state. For a query request
// the stored words are read from the codeword memory one per cycle and each
// runs down a chain of one cell per bit position, a cell adding its bit's
// mismatch to the distance; a collector after the chain keeps the minimum
// distance and the position of the last exact match. The memory read port is
// what sets the rate, one stored codeword per cycle. With an empty store a
// query skips the sweep and goes straight to finish. Requests are stalled
// while a query is in progress; a finished result waits in an output register
// while the next request is taken.
module code_distance_diagram
#(
    parameter int MAX_WORDS = 1024
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              code_length_we,
    input  logic [cdd_pkg::LEN_W-1:0]         code_length,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  cdd_pkg::cmd_t                     cmd,
    output logic                              res_valid,
    input  logic                              res_stall,
    output cdd_pkg::res_t                     res
);

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW = $clog2(MAX_WORDS + 1);
    localparam int MB = cdd_pkg::MAX_BITS;
    localparam int HB = cdd_pkg::HALF_BITS;
    localparam int DW = cdd_pkg::DIST_W;
    localparam int DRW = $clog2(MB + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_WORDS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [cdd_pkg::LEN_W-1:0] len_reg;
    logic [CW-1:0]             count_reg;
    logic [AW-1:0]             rd_addr_reg;
    logic                      rd_valid_reg;
    logic [MB-1:0]             rd_data_reg;
    logic [DRW-1:0]            drain_reg;
    logic [MB-1:0]             mem [MAX_WORDS];

    logic [HB-1:0]             row_reg;
    logic [HB-1:0]             col_reg;
    logic [DW-1:0]             best_reg;
    logic [CW-1:0]             match_reg;
    logic [CW-1:0]             seen_reg;
    logic                      res_valid_reg;
    cdd_pkg::res_t             res_reg;

    logic [DW-1:0]             n_eff;
    logic [MB-1:0]             len_mask;
    logic [MB-1:0]             word_m;
    logic [HB-1:0]             row_next;
    logic [HB-1:0]             col_next;
    logic                      accept;
    logic                      is_query;
    logic                      last_addr;
    logic                      res_free;

    cdd_pkg::link_t            chain [MB+1];

    // clamp length to 1..MAX_BITS
    always_comb
    begin
        if (len_reg == '0)
        begin
            n_eff = DW'(1);
        end
        else if (DW'(len_reg) > DW'(MB))
        begin
            n_eff = DW'(MB);
        end
        else
        begin
            n_eff = DW'(len_reg);
        end
        for (int b = 0; b < MB; b++)
        begin
            len_mask[b] = (DW'(b) < n_eff);
        end
        word_m = cmd.word & len_mask;
        for (int j = 0; j < HB; j++)
        begin
            row_next[j] = word_m[2*j];
            col_next[j] = word_m[2*j+1];
        end
    end

    assign accept = cmd_valid && !cmd_stall;
    assign is_query = (cmd.func == cdd_pkg::FUNC_QUERY);
    assign cmd_stall = (state_reg != ST_IDLE);
    assign last_addr = ((CW'(rd_addr_reg) + CW'(1)) == count_reg);
    assign res_free = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= cdd_pkg::LEN_W'(MB);
        end
        else if (code_length_we)
        begin
            len_reg <= code_length;
        end
    end

    // sequencer and registered control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rd_addr_reg <= '0;
            rd_valid_reg <= 1'b0;
            drain_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == ST_SWEEP);
            if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (cmd.func)
                            cdd_pkg::FUNC_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            cdd_pkg::FUNC_LOAD:
                            begin
                                if (count_reg < FULL_COUNT)
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            cdd_pkg::FUNC_QUERY:
                            begin
                                rd_addr_reg <= '0;
                                state_reg <= (count_reg == '0) ? ST_FINISH : ST_SWEEP;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SWEEP:
                begin
                    if (last_addr)
                    begin
                        drain_reg <= DRW'(MB);
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        rd_addr_reg <= rd_addr_reg + AW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (drain_reg == '0)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        drain_reg <= drain_reg - DRW'(1);
                    end
                end
                ST_FINISH:
                begin
                    if (res_free)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // codeword memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept && cmd.func == cdd_pkg::FUNC_LOAD
            && count_reg < FULL_COUNT)
        begin
            mem[count_reg[AW-1:0]] <= word_m;
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    assign chain[0].valid = rd_valid_reg;
    assign chain[0].cw = rd_data_reg;
    assign chain[0].dsum = '0;

    for (genvar i = 0; i < MB; i++)
    begin : g_cell
        cdd_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (state_reg == ST_IDLE && accept && is_query),
            .q_bit    (word_m[i]),
            .en_bit   (len_mask[i]),
            .link_in  (chain[i]),
            .link_out (chain[i+1])
        );
    end

    // collector: minimum distance and last exact match
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept && is_query)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            best_reg <= n_eff + DW'(1);
            match_reg <= '0;
            seen_reg <= '0;
        end
        else if (chain[MB].valid)
        begin
            seen_reg <= seen_reg + CW'(1);
            if (chain[MB].dsum < best_reg)
            begin
                best_reg <= chain[MB].dsum;
            end
            if (chain[MB].dsum == '0)
            begin
                match_reg <= seen_reg + CW'(1);
            end
        end
        if (state_reg == ST_FINISH && res_free)
        begin
            res_reg.row <= row_reg;
            res_reg.column <= col_reg;
            res_reg.distance <= best_reg;
            res_reg.codeword_index <= cdd_pkg::IDX_W'(match_reg);
        end
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

endmodule

// ----- sim/tb.sv -----
// tb: self-checking testbench for code_distance_diagram (clear, load and query requests)
// keeps its own codeword store to predict every query result, randomizes idling on both sides
// depends on cdd_pkg and code_distance_diagram
`timescale 1ns / 1ps

module tb;

    localparam int WORDS         = 1024;
    localparam int SETTLE_CYCLES = cdd_pkg::MAX_BITS + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int STUCK_LIMIT   = 6000;

    logic                         clk            = 1'b0;
    logic                         rst_n          = 1'b0;
    logic                         code_length_we = 1'b0;
    logic [cdd_pkg::LEN_W-1:0]    code_length    = '0;
    logic                         cmd_valid      = 1'b0;
    logic                         cmd_stall;
    cdd_pkg::cmd_t                cmd            = '0;
    logic                         res_valid;
    logic                         res_stall      = 1'b0;
    cdd_pkg::res_t                res;

    // predictor state
    logic [cdd_pkg::MAX_BITS-1:0] cw_store [WORDS];
    int                           cw_count  = 0;
    logic [cdd_pkg::LEN_W-1:0]    len_reg   = cdd_pkg::LEN_W'(12);
    cdd_pkg::res_t                expected_results [$];

    int                           errors       = 0;
    int                           stuck_cycles = 0;
    bit                           idle_en      = 1'b0;
    bit                           stall_en     = 1'b0;
    bit                           hold_req     = 1'b0;

    code_distance_diagram #(
        .MAX_WORDS (WORDS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .code_length_we (code_length_we),
        .code_length    (code_length),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .cmd            (cmd),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res            (res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // applies one accepted request to the local copy of the store
    task automatic model_request(input cdd_pkg::cmd_t c);
        int                           n;
        int                           best;
        int                           d;
        int                           hit;
        logic [cdd_pkg::MAX_BITS-1:0] mask;
        logic [cdd_pkg::MAX_BITS-1:0] w;
        cdd_pkg::res_t                r;
        n = int'(len_reg);
        if (n < 1)
            n = 1;
        if (n > cdd_pkg::MAX_BITS)
            n = cdd_pkg::MAX_BITS;
        mask = cdd_pkg::MAX_BITS'((1 << n) - 1);
        w = c.word & mask;
        case (c.func)
            cdd_pkg::FUNC_CLEAR: cw_count = 0;
            cdd_pkg::FUNC_LOAD:
            begin
                // a full store drops the word
                if (cw_count < WORDS)
                begin
                    cw_store[cw_count] = w;
                    cw_count++;
                end
            end
            cdd_pkg::FUNC_QUERY:
            begin
                r = '0;
                for (int b = 0; b < n; b++)
                begin
                    if (b % 2 == 0)
                        r.row[b/2] = w[b];
                    else
                        r.column[b/2] = w[b];
                end
                best = n + 1;
                hit = 0;
                for (int k = 0; k < cw_count; k++)
                begin
                    d = $countones((cw_store[k] & mask) ^ w);
                    if (d < best)
                        best = d;
                    if (d == 0)
                        hit = k + 1;
                end
                r.distance = cdd_pkg::DIST_W'(best);
                r.codeword_index = cdd_pkg::IDX_W'(hit);
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input cdd_pkg::res_t got);
        cdd_pkg::res_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("unexpected result, distance", int'(got.distance), -1);
            return;
        end
        want = expected_results.pop_front();
        if (got.row !== want.row)
            report_mismatch("row", int'(got.row), int'(want.row));
        if (got.column !== want.column)
            report_mismatch("column", int'(got.column), int'(want.column));
        if (got.distance !== want.distance)
            report_mismatch("distance", int'(got.distance), int'(want.distance));
        if (got.codeword_index !== want.codeword_index)
            report_mismatch("codeword_index", int'(got.codeword_index),
                            int'(want.codeword_index));
    endtask

    // everything is sampled at the rising edge, inputs move at the falling edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (code_length_we || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (code_length_we)
                len_reg = code_length;
            if (cmd_valid && !cmd_stall)
                model_request(cmd);
            if (res_valid && !res_stall)
                check_result(res);
        end
    end

    initial
    begin
        do
            @(posedge clk);
        while (stuck_cycles < STUCK_LIMIT);
        $display("status: fail");
        $finish;
    end

    // receiver side: random stall bursts, or one long hold-off on demand
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                res_stall <= 1'b0;
            end
            else if (stall_en && $urandom_range(0, 5) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(input logic [1:0] f, input logic [cdd_pkg::MAX_BITS-1:0] w);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= '{func: f, word: w};
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        // a trailing clear or load may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_length(input logic [cdd_pkg::LEN_W-1:0] v);
        code_length_we <= 1'b1;
        code_length <= v;
        @(negedge clk);
        code_length_we <= 1'b0;
    endtask

    task automatic test_basic_ops();
        send_req(cdd_pkg::FUNC_QUERY, 12'hFFF);   // empty store
        send_req(cdd_pkg::FUNC_LOAD, 12'hFFF);
        send_req(cdd_pkg::FUNC_LOAD, 12'h000);
        send_req(cdd_pkg::FUNC_LOAD, 12'hAAA);
        send_req(cdd_pkg::FUNC_LOAD, 12'h555);
        send_req(cdd_pkg::FUNC_QUERY, 12'hFFF);
        send_req(cdd_pkg::FUNC_QUERY, 12'h000);
        send_req(cdd_pkg::FUNC_QUERY, 12'hAAA);
        send_req(cdd_pkg::FUNC_QUERY, 12'h555);
        send_req(cdd_pkg::FUNC_QUERY, 12'h001);
        send_req(cdd_pkg::FUNC_QUERY, 12'h7FF);
        send_req(cdd_pkg::FUNC_NONE, 12'hABC);    // unused code, no effect
        send_req(cdd_pkg::FUNC_LOAD, 12'hAAA);    // duplicate, last position wins
        send_req(cdd_pkg::FUNC_QUERY, 12'hAAA);
        send_req(cdd_pkg::FUNC_CLEAR, 12'hFFF);
        send_req(cdd_pkg::FUNC_QUERY, 12'h123);
    endtask

    task automatic test_length_edges();
        wait_idle();
        set_length(cdd_pkg::LEN_W'(0));           // behaves as length one
        send_req(cdd_pkg::FUNC_CLEAR, 12'h000);
        send_req(cdd_pkg::FUNC_LOAD, 12'hFFF);
        send_req(cdd_pkg::FUNC_QUERY, 12'hFFE);
        send_req(cdd_pkg::FUNC_QUERY, 12'h001);
        wait_idle();
        set_length(cdd_pkg::LEN_W'(15));          // saturates to the widest word
        send_req(cdd_pkg::FUNC_QUERY, 12'hFFF);
        wait_idle();
        set_length(cdd_pkg::LEN_W'(13));
        send_req(cdd_pkg::FUNC_QUERY, 12'h000);
        wait_idle();
        set_length(cdd_pkg::LEN_W'(12));
        send_req(cdd_pkg::FUNC_CLEAR, 12'h000);
        send_req(cdd_pkg::FUNC_LOAD, 12'hF0F);
        wait_idle();
        set_length(cdd_pkg::LEN_W'(4));           // stored word is compared under the new mask
        send_req(cdd_pkg::FUNC_QUERY, 12'h00F);
        send_req(cdd_pkg::FUNC_QUERY, 12'h0F0);
    endtask

    task automatic test_backpressure();
        wait_idle();
        send_req(cdd_pkg::FUNC_CLEAR, 12'h000);
        for (int k = 0; k < 3; k++)
            send_req(cdd_pkg::FUNC_LOAD, cdd_pkg::MAX_BITS'($urandom));
        hold_req = 1'b1;
        for (int k = 0; k < 10; k++)
            send_req(cdd_pkg::FUNC_QUERY, cdd_pkg::MAX_BITS'($urandom));
    endtask

    // phases of clear, loads and queries under a new length, with some noise
    task automatic test_random_phases(input int item_goal);
        int                           sent;
        int                           phase;
        int                           n_load;
        int                           n_query;
        int                           pick;
        logic [cdd_pkg::LEN_W-1:0]    len;
        logic [cdd_pkg::MAX_BITS-1:0] w;
        logic [cdd_pkg::MAX_BITS-1:0] loaded [$];
        sent = 0;
        phase = 0;
        while (sent < item_goal)
        begin
            wait_idle();
            case (phase)
                0:       len = cdd_pkg::LEN_W'(1);
                1:       len = cdd_pkg::LEN_W'(12);
                default: len = cdd_pkg::LEN_W'($urandom_range(0, 15));
            endcase
            set_length(len);
            loaded.delete();
            if ($urandom_range(0, 4) != 0)
            begin
                send_req(cdd_pkg::FUNC_CLEAR, cdd_pkg::MAX_BITS'($urandom));
                sent++;
            end
            n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 150)
                                                 : $urandom_range(0, 40);
            for (int k = 0; k < n_load; k++)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    send_req(2'($urandom_range(0, 3)), cdd_pkg::MAX_BITS'($urandom));
                    sent++;
                end
                w = cdd_pkg::MAX_BITS'($urandom);
                send_req(cdd_pkg::FUNC_LOAD, w);
                loaded.push_back(w);
                sent++;
            end
            n_query = $urandom_range(1, 8);
            for (int k = 0; k < n_query; k++)
            begin
                pick = $urandom_range(0, 3);
                if (loaded.size() > 0 && pick < 3)
                begin
                    w = loaded[$urandom_range(0, loaded.size() - 1)];
                    // near miss: one or two random bit flips on a stored word
                    if (pick >= 1)
                        w[$urandom_range(0, cdd_pkg::MAX_BITS - 1)] ^= 1'b1;
                    if (pick == 2)
                        w[$urandom_range(0, cdd_pkg::MAX_BITS - 1)] ^= 1'b1;
                end
                else
                    w = cdd_pkg::MAX_BITS'($urandom);
                send_req(cdd_pkg::FUNC_QUERY, w);
                sent++;
            end
            phase++;
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_en = 1'b1;
        stall_en = 1'b1;
        test_basic_ops();
        test_length_edges();
        test_backpressure();
        test_random_phases(450);
        idle_en = 1'b0;
        stall_en = 1'b0;
        test_random_phases(40);
        wait_idle();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/cdd_pkg.sv
hw/rtl/cdd_cell.sv
hw/rtl/code_distance_diagram.sv
sim/tb.sv
